// ===== hdl/grq_pkg.sv =====
// ----------------------------------------------------------------------------
// grq_pkg
// shared widths, register indexes, limits, state and interface types for the
// gain ranging quantizer
// ----------------------------------------------------------------------------
package grq_pkg;

  // field and register widths
  localparam int SAMPLE_W    = 32;
  localparam int MANT_W      = 25;
  localparam int INDEX_W     = 3;
  localparam int RECON_W     = 48;
  localparam int MANT_BITS_W = 5;
  localparam int LEVEL_W     = 31;
  localparam int COUNT_W     = 3;
  localparam int GAIN_W      = 12;
  localparam int NUM_GAINS   = 4;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 31;

  // internal arithmetic widths
  localparam int MAG_W   = 24;                 // mantissa magnitude
  localparam int DEN_W   = LEVEL_W + GAIN_W;   // level * first gain
  localparam int NUM_W   = SAMPLE_W + GAIN_W;  // sample magnitude * gain
  localparam int REM_W   = DEN_W;              // divider remainder
  localparam int QUO_W   = 48;                 // divider quotient / dividend
  localparam int P_W     = 54;                 // mantissa * level
  localparam int HALF_W  = 27;                 // split of p for partial products
  localparam int PART_W  = HALF_W + GAIN_W;
  localparam int PROD_W  = P_W + GAIN_W;       // p * first gain
  localparam int TRIAL_STEPS = 24;
  localparam int RECON_STEPS = 48;
  localparam int STEP_W      = 6;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MANT_BITS   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_COUNT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_FIRST  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_SECOND = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_THIRD  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_GAIN_FOURTH = 3'd6;

  // reset values and limits
  localparam logic [MANT_BITS_W-1:0] MANT_BITS_RESET = 5'd14;
  localparam logic [LEVEL_W-1:0]     LEVEL_RESET     = 31'd65536;
  localparam logic [COUNT_W-1:0]     COUNT_RESET     = 3'd1;
  localparam logic [GAIN_W-1:0]      GAIN_RESET      = 12'd1;
  localparam logic [MANT_BITS_W-1:0] MANT_BITS_MIN   = 5'd2;
  localparam logic [MANT_BITS_W-1:0] MANT_BITS_MAX   = 5'd24;
  localparam logic [COUNT_W-1:0]     COUNT_MAX       = 3'd4;
  localparam logic [INDEX_W-1:0]     CLIP_INDEX      = 3'd4;
  localparam logic [RECON_W:0]       RECON_POS_LIMIT = 49'h0_7FFF_FFFF_FFFF;
  localparam logic [RECON_W:0]       RECON_NEG_LIMIT = 49'h0_8000_0000_0000;

  // sanitized configuration
  typedef struct packed {
    logic [MANT_BITS_W-1:0]             mant_bits;
    logic [LEVEL_W-1:0]                 level;
    logic [COUNT_W-1:0]                 count;
    logic [NUM_GAINS-1:0][GAIN_W-1:0]   gain;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic trial_mul;
    logic trial_load;
    logic div_step;
    logic trial_accept;
    logic next_gain;
    logic clip_select;
    logic recon_p;
    logic recon_lo;
    logic recon_hi;
    logic recon_load;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trial_early;
    logic trial_fit;
    logic last_trial;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL_MUL,
    S_TRIAL_LOAD,
    S_TRIAL_DIV,
    S_TRIAL_EVAL,
    S_RECON_P,
    S_RECON_LO,
    S_RECON_HI,
    S_RECON_LOAD,
    S_RECON_DIV,
    S_FINISH
  } state_t;

endpackage

// ===== hdl/grq_regs.sv =====
// ----------------------------------------------------------------------------
// grq_regs
// configuration registers with write port; presents sanitized values
// ----------------------------------------------------------------------------
module grq_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [grq_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [grq_pkg::CFG_DATA_W-1:0]   cfg_data,
  output grq_pkg::cfg_t                    cfg
);

  logic [grq_pkg::MANT_BITS_W-1:0]                  mant_bits;
  logic [grq_pkg::LEVEL_W-1:0]                      level;
  logic [grq_pkg::COUNT_W-1:0]                      count;
  logic [grq_pkg::NUM_GAINS-1:0][grq_pkg::GAIN_W-1:0] gain;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      mant_bits <= grq_pkg::MANT_BITS_RESET;
      level     <= grq_pkg::LEVEL_RESET;
      count     <= grq_pkg::COUNT_RESET;
      for (int i = 0; i < grq_pkg::NUM_GAINS; i++) begin
        gain[i] <= grq_pkg::GAIN_RESET;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        grq_pkg::REG_MANT_BITS:   mant_bits <= cfg_data[grq_pkg::MANT_BITS_W-1:0];
        grq_pkg::REG_LEVEL:       level     <= cfg_data[grq_pkg::LEVEL_W-1:0];
        grq_pkg::REG_GAIN_COUNT:  count     <= cfg_data[grq_pkg::COUNT_W-1:0];
        grq_pkg::REG_GAIN_FIRST:  gain[0]   <= cfg_data[grq_pkg::GAIN_W-1:0];
        grq_pkg::REG_GAIN_SECOND: gain[1]   <= cfg_data[grq_pkg::GAIN_W-1:0];
        grq_pkg::REG_GAIN_THIRD:  gain[2]   <= cfg_data[grq_pkg::GAIN_W-1:0];
        grq_pkg::REG_GAIN_FOURTH: gain[3]   <= cfg_data[grq_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp mantissa width, count, and map zero level or gain to one
  always_comb begin
    if (mant_bits < grq_pkg::MANT_BITS_MIN) begin
      cfg.mant_bits = grq_pkg::MANT_BITS_MIN;
    end else if (mant_bits > grq_pkg::MANT_BITS_MAX) begin
      cfg.mant_bits = grq_pkg::MANT_BITS_MAX;
    end else begin
      cfg.mant_bits = mant_bits;
    end
    cfg.level = (level == '0) ? grq_pkg::LEVEL_W'(1) : level;
    if (count == '0) begin
      cfg.count = grq_pkg::COUNT_W'(1);
    end else if (count > grq_pkg::COUNT_MAX) begin
      cfg.count = grq_pkg::COUNT_MAX;
    end else begin
      cfg.count = count;
    end
    for (int i = 0; i < grq_pkg::NUM_GAINS; i++) begin
      cfg.gain[i] = (gain[i] == '0) ? grq_pkg::GAIN_W'(1) : gain[i];
    end
  end

endmodule

// ===== hdl/grq_datapath.sv =====
// ----------------------------------------------------------------------------
// grq_datapath
// gain trials and reconstruction on one shared restoring divider, plus the
// output register
// ----------------------------------------------------------------------------
module grq_datapath (
  input  logic                                clk,
  input  grq_pkg::cfg_t                       cfg,
  input  grq_pkg::cmd_t                       cmd,
  input  logic signed [grq_pkg::SAMPLE_W-1:0] sample,
  output grq_pkg::status_t                    status,
  output logic signed [grq_pkg::MANT_W-1:0]   mantissa,
  output logic [grq_pkg::INDEX_W-1:0]         gain_index,
  output logic                                clipped,
  output logic signed [grq_pkg::RECON_W-1:0]  reconstructed
);

  logic                          neg;
  logic [grq_pkg::SAMPLE_W-1:0]  smag;
  logic [grq_pkg::DEN_W-1:0]     den;
  logic [grq_pkg::INDEX_W-1:0]   idx;
  logic [grq_pkg::NUM_W-1:0]     num;
  logic [grq_pkg::DEN_W-1:0]     divisor;
  logic [grq_pkg::REM_W-1:0]     rem;
  logic [grq_pkg::QUO_W-1:0]     dsr;
  logic [grq_pkg::QUO_W-1:0]     quot;
  logic [grq_pkg::MAG_W-1:0]     mmag;
  logic [grq_pkg::GAIN_W-1:0]    g_used;
  logic                          clip;
  logic [grq_pkg::P_W-1:0]       p;
  logic [grq_pkg::PROD_W-1:0]    prod;
  logic                          rsat;

  logic [grq_pkg::SAMPLE_W-1:0]  smag_in;
  logic [grq_pkg::GAIN_W-1:0]    gain_cur;
  logic [grq_pkg::DEN_W-1:0]     den_full;
  logic [grq_pkg::NUM_W-1:0]     num_full;
  logic [grq_pkg::P_W:0]         p_full;
  logic [grq_pkg::PART_W-1:0]    part_lo;
  logic [grq_pkg::PART_W-1:0]    part_hi;
  logic [grq_pkg::MAG_W-1:0]     range;
  logic [grq_pkg::REM_W:0]       trial_sub;
  logic [grq_pkg::REM_W:0]       diff;
  logic                          ge;
  logic [grq_pkg::REM_W-1:0]     rem_next;
  logic                          round_up;
  logic [grq_pkg::MAG_W:0]       q_trial;
  logic [grq_pkg::RECON_W:0]     rq;
  logic [grq_pkg::RECON_W:0]     limit;
  logic [grq_pkg::RECON_W:0]     rmag;
  logic [grq_pkg::MANT_W-1:0]    mant_val;
  logic [grq_pkg::RECON_W-1:0]   recon_val;

  // sample magnitude, gain under trial and range
  assign smag_in  = sample[grq_pkg::SAMPLE_W-1] ?
                    (grq_pkg::SAMPLE_W'(0) - grq_pkg::SAMPLE_W'(sample)) :
                    grq_pkg::SAMPLE_W'(sample);
  assign gain_cur = cfg.gain[idx[1:0]];
  assign range    = (grq_pkg::MAG_W'(1) << (cfg.mant_bits - grq_pkg::MANT_BITS_W'(1)))
                    - grq_pkg::MAG_W'(1);

  // multipliers, each registered before use
  assign den_full = grq_pkg::DEN_W'(cfg.level) * grq_pkg::DEN_W'(cfg.gain[0]);
  assign num_full = grq_pkg::NUM_W'(smag) * grq_pkg::NUM_W'(gain_cur);
  assign p_full   = (grq_pkg::P_W + 1)'(mmag) * (grq_pkg::P_W + 1)'(cfg.level);
  assign part_lo  = grq_pkg::PART_W'(p[grq_pkg::HALF_W-1:0])
                    * grq_pkg::PART_W'(cfg.gain[0]);
  assign part_hi  = grq_pkg::PART_W'(p[grq_pkg::P_W-1:grq_pkg::HALF_W])
                    * grq_pkg::PART_W'(cfg.gain[0]);

  // one restoring divider step
  assign trial_sub = {rem, dsr[grq_pkg::QUO_W-1]};
  assign ge        = trial_sub >= {1'b0, divisor};
  assign diff      = trial_sub - {1'b0, divisor};
  assign rem_next  = ge ? diff[grq_pkg::REM_W-1:0] : trial_sub[grq_pkg::REM_W-1:0];
  assign round_up  = {rem, 1'b0} >= {1'b0, divisor};

  // trial outcome
  assign q_trial = {1'b0, quot[grq_pkg::MAG_W-1:0]} + (grq_pkg::MAG_W + 1)'(round_up);
  assign status.trial_early = grq_pkg::DEN_W'(num[grq_pkg::NUM_W-1:grq_pkg::TRIAL_STEPS])
                              >= den;
  assign status.trial_fit   = q_trial <= {1'b0, range};
  assign status.last_trial  = ({1'b0, idx} + 4'd1) >= {1'b0, cfg.count};

  // reconstruction rounding and saturation
  assign rq        = {1'b0, quot} + (grq_pkg::RECON_W + 1)'(round_up);
  assign limit     = neg ? grq_pkg::RECON_NEG_LIMIT : grq_pkg::RECON_POS_LIMIT;
  assign rmag      = (rsat || (rq > limit)) ? limit : rq;
  assign recon_val = neg ? (grq_pkg::RECON_W'(0) - rmag[grq_pkg::RECON_W-1:0]) :
                     rmag[grq_pkg::RECON_W-1:0];
  assign mant_val  = neg ? (grq_pkg::MANT_W'(0) - {1'b0, mmag}) : {1'b0, mmag};

  // item capture and gain selection
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      neg  <= sample[grq_pkg::SAMPLE_W-1];
      smag <= smag_in;
      den  <= den_full;
      idx  <= '0;
    end else if (cmd.next_gain) begin
      idx <= idx + grq_pkg::INDEX_W'(1);
    end else if (cmd.clip_select) begin
      idx <= grq_pkg::CLIP_INDEX;
    end
    if (cmd.trial_mul) begin
      num <= num_full;
    end
    if (cmd.trial_accept) begin
      mmag   <= q_trial[grq_pkg::MAG_W-1:0];
      g_used <= gain_cur;
      clip   <= 1'b0;
    end else if (cmd.clip_select) begin
      mmag   <= range + grq_pkg::MAG_W'(1);
      g_used <= grq_pkg::GAIN_W'(1);
      clip   <= 1'b1;
    end
  end

  // reconstruction product in partial products
  always_ff @(posedge clk) begin
    if (cmd.recon_p) begin
      p <= p_full[grq_pkg::P_W-1:0];
    end
    if (cmd.recon_lo) begin
      prod <= grq_pkg::PROD_W'(part_lo);
    end else if (cmd.recon_hi) begin
      prod <= prod + {part_hi, grq_pkg::HALF_W'(0)};
    end
  end

  // shared divider: load for a trial or for reconstruction, then step
  always_ff @(posedge clk) begin
    if (cmd.trial_load) begin
      divisor <= den;
      rem     <= grq_pkg::REM_W'(num[grq_pkg::NUM_W-1:grq_pkg::TRIAL_STEPS]);
      dsr     <= {num[grq_pkg::TRIAL_STEPS-1:0], grq_pkg::TRIAL_STEPS'(0)};
      quot    <= '0;
    end else if (cmd.recon_load) begin
      divisor <= grq_pkg::DEN_W'(g_used);
      rem     <= grq_pkg::REM_W'(prod[grq_pkg::PROD_W-1:grq_pkg::QUO_W]);
      dsr     <= prod[grq_pkg::QUO_W-1:0];
      quot    <= '0;
      rsat    <= prod[grq_pkg::PROD_W-1:grq_pkg::QUO_W]
                 >= (grq_pkg::PROD_W - grq_pkg::QUO_W)'(g_used);
    end else if (cmd.div_step) begin
      rem  <= rem_next;
      dsr  <= {dsr[grq_pkg::QUO_W-2:0], 1'b0};
      quot <= {quot[grq_pkg::QUO_W-2:0], ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mantissa      <= mant_val;
      gain_index    <= idx;
      clipped       <= clip;
      reconstructed <= recon_val;
    end
  end

endmodule

// ===== hdl/grq_ctrl.sv =====
// ----------------------------------------------------------------------------
// grq_ctrl
// sequencer for gain trials, reconstruction and output handshake
// ----------------------------------------------------------------------------
module grq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  grq_pkg::status_t  status,
  output grq_pkg::cmd_t     cmd
);

  grq_pkg::state_t              state;
  grq_pkg::state_t              state_next;
  logic [grq_pkg::STEP_W-1:0]   count;
  logic [grq_pkg::STEP_W-1:0]   count_next;

  // state, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= grq_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // no transaction is taken while reset is held
  assign in_ready = (state == grq_pkg::S_IDLE) && !rst;

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      grq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = grq_pkg::S_TRIAL_MUL;
        end
      end
      grq_pkg::S_TRIAL_MUL: begin
        cmd.trial_mul = 1'b1;
        state_next    = grq_pkg::S_TRIAL_LOAD;
      end
      grq_pkg::S_TRIAL_LOAD: begin
        // quotient already too large: skip the division
        if (status.trial_early) begin
          if (status.last_trial) begin
            cmd.clip_select = 1'b1;
            state_next      = grq_pkg::S_RECON_P;
          end else begin
            cmd.next_gain = 1'b1;
            state_next    = grq_pkg::S_TRIAL_MUL;
          end
        end else begin
          cmd.trial_load = 1'b1;
          count_next     = '0;
          state_next     = grq_pkg::S_TRIAL_DIV;
        end
      end
      grq_pkg::S_TRIAL_DIV: begin
        cmd.div_step = 1'b1;
        if (count == grq_pkg::STEP_W'(grq_pkg::TRIAL_STEPS - 1)) begin
          state_next = grq_pkg::S_TRIAL_EVAL;
        end else begin
          count_next = count + grq_pkg::STEP_W'(1);
        end
      end
      grq_pkg::S_TRIAL_EVAL: begin
        if (status.trial_fit) begin
          cmd.trial_accept = 1'b1;
          state_next       = grq_pkg::S_RECON_P;
        end else if (status.last_trial) begin
          cmd.clip_select = 1'b1;
          state_next      = grq_pkg::S_RECON_P;
        end else begin
          cmd.next_gain = 1'b1;
          state_next    = grq_pkg::S_TRIAL_MUL;
        end
      end
      grq_pkg::S_RECON_P: begin
        cmd.recon_p = 1'b1;
        state_next  = grq_pkg::S_RECON_LO;
      end
      grq_pkg::S_RECON_LO: begin
        cmd.recon_lo = 1'b1;
        state_next   = grq_pkg::S_RECON_HI;
      end
      grq_pkg::S_RECON_HI: begin
        cmd.recon_hi = 1'b1;
        state_next   = grq_pkg::S_RECON_LOAD;
      end
      grq_pkg::S_RECON_LOAD: begin
        cmd.recon_load = 1'b1;
        count_next     = '0;
        state_next     = grq_pkg::S_RECON_DIV;
      end
      grq_pkg::S_RECON_DIV: begin
        cmd.div_step = 1'b1;
        if (count == grq_pkg::STEP_W'(grq_pkg::RECON_STEPS - 1)) begin
          state_next = grq_pkg::S_FINISH;
        end else begin
          count_next = count + grq_pkg::STEP_W'(1);
        end
      end
      grq_pkg::S_FINISH: begin
        // wait for room in the output register
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = grq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = grq_pkg::S_IDLE;
      end
    endcase
  end

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register overwritten while a transaction is pending");

  // an accepted transaction always starts with the first trial multiply
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.load_item |=> (state == grq_pkg::S_TRIAL_MUL))
    else $error("accepted transaction did not start a trial");

  // trial division never runs past its step count
  a_trial_count: assert property (@(posedge clk) disable iff (rst)
    (state == grq_pkg::S_TRIAL_DIV) |-> (count < grq_pkg::STEP_W'(grq_pkg::TRIAL_STEPS)))
    else $error("trial divider step count out of bounds");

  // output valid only rises out of the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == grq_pkg::S_FINISH))
    else $error("output valid raised outside the finish state");

endmodule

// ===== hdl/gain_ranging_quantizer.sv =====
// ----------------------------------------------------------------------------
// gain_ranging_quantizer: one sample at a time on a shared restoring divider
// each sample runs a 24-step trial division per gain tried (1..4), then a
// 48-step reconstruction division; a gain rejected by the pre-check skips its
// division. A new sample is taken only when idle; the output register frees
// the input, so the next sample can start while a result waits for out_ready
// synchronous active-high reset: idle, no result pending, registers at defaults
// ----------------------------------------------------------------------------
module gain_ranging_quantizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [grq_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [grq_pkg::MANT_W-1:0]   mantissa,
  output logic [grq_pkg::INDEX_W-1:0]         gain_index,
  output logic                                clipped,
  output logic signed [grq_pkg::RECON_W-1:0]  reconstructed,
  input  logic                                cfg_write,
  input  logic [grq_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [grq_pkg::CFG_DATA_W-1:0]      cfg_data
);

  grq_pkg::cfg_t     cfg;
  grq_pkg::cmd_t     cmd;
  grq_pkg::status_t  status;

  // configuration registers
  grq_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  grq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // arithmetic and output register
  grq_datapath u_datapath (
    .clk           (clk),
    .cfg           (cfg),
    .cmd           (cmd),
    .sample        (sample),
    .status        (status),
    .mantissa      (mantissa),
    .gain_index    (gain_index),
    .clipped       (clipped),
    .reconstructed (reconstructed)
  );

endmodule

// ===== tb/gain_ranging_quantizer_test.sv =====
// ----------------------------------------------------------------------------
// gain_ranging_quantizer_test
// self-checking bench for the gain ranging quantizer: a negedge driver feeds
// samples from a queue, a posedge monitor predicts each accepted transaction
// and compares every result field in order; registers are rewritten between
// phases while the block is idle, with random gaps and back pressure
// ----------------------------------------------------------------------------
module gain_ranging_quantizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int HOLD_OFF_CYCLES = 600;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_SAMPLES   = 125;
  // decodes to no register
  localparam logic [grq_pkg::CFG_INDEX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic signed [grq_pkg::MANT_W-1:0]  mantissa;
    logic [grq_pkg::INDEX_W-1:0]        gain_index;
    logic                               clipped;
    logic signed [grq_pkg::RECON_W-1:0] reconstructed;
  } quant_result_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic signed [grq_pkg::SAMPLE_W-1:0] sample = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [grq_pkg::MANT_W-1:0]   mantissa;
  logic [grq_pkg::INDEX_W-1:0]         gain_index;
  logic                                clipped;
  logic signed [grq_pkg::RECON_W-1:0]  reconstructed;
  logic                                cfg_write = 1'b0;
  logic [grq_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [grq_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  // register copies as the block should hold them
  logic [grq_pkg::MANT_BITS_W-1:0] set_bits = grq_pkg::MANT_BITS_RESET;
  logic [grq_pkg::LEVEL_W-1:0]     set_level = grq_pkg::LEVEL_RESET;
  logic [grq_pkg::COUNT_W-1:0]     set_count = grq_pkg::COUNT_RESET;
  logic [grq_pkg::GAIN_W-1:0]      set_gain [grq_pkg::NUM_GAINS] =
                                     '{default: grq_pkg::GAIN_RESET};

  logic signed [grq_pkg::SAMPLE_W-1:0] pending_samples [$];
  quant_result_t                       expected_results [$];

  logic in_fire = 1'b0;
  logic quiet_phase = 1'b0;
  logic hold_off_req = 1'b0;
  logic hold_off_done = 1'b0;
  int   send_gap = 0;
  int   hold_cycles = 0;
  int   cycles = 0;
  int   mismatches = 0;
  int   samples_taken = 0;
  int   results_seen = 0;
  int   settings_used = 1;
  int   index_hits [grq_pkg::NUM_GAINS+1] = '{default: 0};

  gain_ranging_quantizer DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample        (sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .mantissa      (mantissa),
    .gain_index    (gain_index),
    .clipped       (clipped),
    .reconstructed (reconstructed),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // effective register values: zero gain and zero level act as one
  function automatic logic [63:0] gain_value(input int k);
    return (set_gain[k] == '0) ? 64'd1 : 64'(set_gain[k]);
  endfunction

  function automatic logic [63:0] eff_level();
    return (set_level == '0) ? 64'd1 : 64'(set_level);
  endfunction

  function automatic logic [63:0] mant_range();
    logic [63:0] b;
    b = 64'(set_bits);
    if (b < 64'(grq_pkg::MANT_BITS_MIN)) b = 64'(grq_pkg::MANT_BITS_MIN);
    if (b > 64'(grq_pkg::MANT_BITS_MAX)) b = 64'(grq_pkg::MANT_BITS_MAX);
    return ((64'd1 << b) - 64'd1) / 64'd2;
  endfunction

  function automatic int gains_tried();
    if (set_count == '0) return 1;
    if (set_count > grq_pkg::COUNT_MAX) return grq_pkg::NUM_GAINS;
    return int'(set_count);
  endfunction

  // expected result for one sample under the current registers
  function automatic quant_result_t quantize(input logic signed [grq_pkg::SAMPLE_W-1:0] s);
    quant_result_t res;
    logic        neg, fit;
    logic [63:0] raw, smag, lvl, gf, den, rng, mmag, g, num, q;
    logic [63:0] p, q1, r1, add, lim, rmag;
    logic [grq_pkg::INDEX_W-1:0] idx;
    int k;
    raw  = {32'd0, s};
    neg  = s[grq_pkg::SAMPLE_W-1];
    smag = neg ? 64'h1_0000_0000 - raw : raw;
    lvl  = eff_level();
    gf   = gain_value(0);
    den  = lvl * gf;
    rng  = mant_range();
    // try gains in register order, first fit wins
    fit  = 1'b0;
    mmag = rng + 64'd1;
    g    = 64'd1;
    idx  = grq_pkg::CLIP_INDEX;
    for (k = 0; k < gains_tried() && !fit; k++) begin
      num = smag * gain_value(k);
      q = (64'd2 * num + den) / (64'd2 * den);
      if (q <= rng) begin
        fit  = 1'b1;
        mmag = q;
        g    = gain_value(k);
        idx  = grq_pkg::INDEX_W'(k);
      end
    end
    // reconstruction, rounded half away from zero and saturated
    lim = neg ? 64'(grq_pkg::RECON_NEG_LIMIT) : 64'(grq_pkg::RECON_POS_LIMIT);
    p   = mmag * lvl;
    q1  = p / g;
    r1  = p % g;
    add = (64'd2 * r1 * gf + g) / (64'd2 * g);
    if (q1 > lim / gf) rmag = lim;
    else if (q1 * gf > lim - add) rmag = lim;
    else rmag = q1 * gf + add;
    res.mantissa      = grq_pkg::MANT_W'(neg ? 64'd0 - mmag : mmag);
    res.gain_index    = idx;
    res.clipped       = !fit;
    res.reconstructed = grq_pkg::RECON_W'(neg ? 64'd0 - rmag : rmag);
    return res;
  endfunction

  // mostly short gaps, a few long ones, none in a quiet phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sample mix: log-spread magnitudes, rounding edges of each gain,
  // raw random words and the extremes
  function automatic logic signed [grq_pkg::SAMPLE_W-1:0] pick_sample();
    logic [63:0] mag, den;
    logic        neg;
    int          mode;
    mode = $urandom_range(0, 9);
    neg  = 1'($urandom_range(0, 1));
    case (mode)
      0, 1, 2, 3: mag = 64'($urandom >> $urandom_range(0, 31));
      4, 5, 6: begin
        den = eff_level() * gain_value(0);
        if ((den >> 32) != 0) mag = 64'd1 << 31;
        else mag = ((64'd2 * mant_range() + 64'd1) * den) /
                   (64'd2 * gain_value($urandom_range(0, gains_tried() - 1)));
        mag = mag + 64'($urandom_range(0, 4));
        mag = (mag < 64'd2) ? 64'd0 : mag - 64'd2;
      end
      7, 8: return grq_pkg::SAMPLE_W'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          default: return '1;
        endcase
      end
    endcase
    if (mag > 64'h8000_0000) mag = 64'h8000_0000;
    if (neg) return grq_pkg::SAMPLE_W'(64'd0 - mag);
    return grq_pkg::SAMPLE_W'((mag > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mag);
  endfunction

  // one register write per cycle, cfg_write left high for the caller to drop
  task automatic write_reg(input logic [grq_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [grq_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      grq_pkg::REG_MANT_BITS:   set_bits = data[grq_pkg::MANT_BITS_W-1:0];
      grq_pkg::REG_LEVEL:       set_level = data[grq_pkg::LEVEL_W-1:0];
      grq_pkg::REG_GAIN_COUNT:  set_count = data[grq_pkg::COUNT_W-1:0];
      grq_pkg::REG_GAIN_FIRST:  set_gain[0] = data[grq_pkg::GAIN_W-1:0];
      grq_pkg::REG_GAIN_SECOND: set_gain[1] = data[grq_pkg::GAIN_W-1:0];
      grq_pkg::REG_GAIN_THIRD:  set_gain[2] = data[grq_pkg::GAIN_W-1:0];
      grq_pkg::REG_GAIN_FOURTH: set_gain[3] = data[grq_pkg::GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // full register set; unused upper data bits carry noise
  task automatic set_config(input logic [grq_pkg::MANT_BITS_W-1:0] bits,
                            input logic [grq_pkg::LEVEL_W-1:0] lvl,
                            input logic [grq_pkg::COUNT_W-1:0] cnt,
                            input logic [grq_pkg::GAIN_W-1:0] g0, g1, g2, g3);
    write_reg(grq_pkg::REG_MANT_BITS,   {26'($urandom), bits});
    write_reg(grq_pkg::REG_LEVEL,       lvl);
    write_reg(grq_pkg::REG_GAIN_COUNT,  {28'($urandom), cnt});
    write_reg(grq_pkg::REG_GAIN_FIRST,  {19'($urandom), g0});
    write_reg(grq_pkg::REG_GAIN_SECOND, {19'($urandom), g1});
    write_reg(grq_pkg::REG_GAIN_THIRD,  {19'($urandom), g2});
    write_reg(grq_pkg::REG_GAIN_FOURTH, {19'($urandom), g3});
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // block is idle once every sample went in and every result came back;
  // checked a little after the falling edge so the driver's update has landed
  task automatic wait_idle();
    @(negedge clk);
    #1;
    while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0) begin
      @(negedge clk);
      #1;
    end
  endtask

  task automatic compare_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_samples.size() != 0) begin
        in_valid <= 1'b1;
        sample   <= pending_samples.pop_front();
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        hold_cycles = HOLD_OFF_CYCLES;
      end else if (hold_cycles == 0 && $urandom_range(0, 3) == 0) begin
        hold_cycles = pick_gap();
      end
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict newly accepted samples
  always @(posedge clk) begin : monitor
    quant_result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none actual mantissa %0d gain_index %0d",
                   $time, mantissa, gain_index);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("mantissa", want.mantissa, mantissa);
          compare_field("gain_index", want.gain_index, gain_index);
          compare_field("clipped", want.clipped, clipped);
          compare_field("reconstructed", want.reconstructed, reconstructed);
          index_hits[want.gain_index]++;
          results_seen++;
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(quantize(sample));
        samples_taken++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    logic [grq_pkg::GAIN_W-1:0]      g [grq_pkg::NUM_GAINS];
    logic [grq_pkg::MANT_BITS_W-1:0] bits;
    logic [grq_pkg::LEVEL_W-1:0]     lvl;
    logic [grq_pkg::COUNT_W-1:0]     cnt;
    int ph, k;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: rounding edge of the top mantissa, both signs, extremes
    @(posedge clk);
    pending_samples = '{0, 1, -1, 32768, -32768, 32767, 536838143, 536838144,
                        -536838143, -536838144, 32'h7FFF_FFFF, 32'h8000_0000};
    wait_idle();

    // zero level, zero count, zero gains among nonzero ones, narrow mantissa,
    // and a write to the unused index
    write_reg(REG_NONE, grq_pkg::CFG_DATA_W'($urandom));
    set_config(5'd0, 31'd0, 3'd0, 12'd0, 12'd4095, 12'd0, 12'd7);
    @(posedge clk);
    pending_samples = '{0, 1, -1, 2, -2, 32'h7FFF_FFFF};
    wait_idle();

    // widest mantissa past its limit, count past its limit, gains out of order
    set_config(5'd31, 31'd1, 3'd7, 12'd4095, 12'd9, 12'd4000, 12'd1);
    @(posedge clk);
    pending_samples = '{32'h7FFF_FFFF, 32'h8000_0000, 8388608, 8388607,
                        -8388607, 1};
    wait_idle();

    // random phases
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        set_config(5'd24, 31'd1, 3'd4, 12'd4095, 12'd1024, 12'd64, 12'd1);
      end else if (ph == 1) begin
        set_config(5'd2, 31'h7FFF_FFFF, 3'd1, 12'd1, 12'd4095, 12'd4095, 12'd4095);
      end else begin
        bits = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(2, 24));
        lvl  = 31'($urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30));
        cnt  = ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
        g[0] = 12'($urandom_range(1, 4095));
        for (k = 1; k < grq_pkg::NUM_GAINS; k++)
          g[k] = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                              : 12'($urandom_range(1, g[k-1]));
        set_config(bits, lvl, cnt, g[0], g[1], g[2], g[3]);
      end
      @(negedge clk);
      quiet_phase <= (ph == 2);
      @(posedge clk);
      repeat (PHASE_SAMPLES) pending_samples.push_back(pick_sample());
      // long receiver stall while the sender keeps offering
      if (ph == 3) begin
        @(negedge clk);
        hold_off_req <= 1'b1;
      end
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d samples under %0d register settings, %0d results checked",
             samples_taken, settings_used, results_seen);
    $display("results per gain index 0..3: %0d %0d %0d %0d, clipped: %0d",
             index_hits[0], index_hits[1], index_hits[2], index_hits[3], index_hits[4]);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
